### hw/rtl/pdbr_pkg.sv
// Package for the pulse-distance byte receiver.
// Threshold register indexes, reset values and the threshold bundle type.
// No dependencies.
package pdbr_pkg;

  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 4;

  // threshold register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_END = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_END    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIT    = CFG_IDX_W'(3);

  localparam logic [THRESH_W-1:0] RST_MESSAGE_END = THRESH_W'(200);
  localparam logic [THRESH_W-1:0] RST_BYTE_END    = THRESH_W'(160);
  localparam logic [THRESH_W-1:0] RST_ONE_BIT     = THRESH_W'(120);
  localparam logic [THRESH_W-1:0] RST_ZERO_BIT    = THRESH_W'(80);

  typedef struct packed {
    logic [THRESH_W-1:0] message_end;
    logic [THRESH_W-1:0] byte_end;
    logic [THRESH_W-1:0] one_bit;
    logic [THRESH_W-1:0] zero_bit;
  } pdbr_thresh_t;

endpackage

### hw/rtl/pulse_distance_byte_receiver_core.sv
// Path: input register, then decoder, then the m_axis output register.
// Throughput: one line sample per cycle unless m_axis stalls; the tick counter and
// thresholds are checked in one registered step between input and output registers.
// Reset: async active low; disarms, clears counter and shifter, empties both
// registers, thresholds return to 200/160/120/80 ticks.
// Top level of the pulse-distance byte receiver; uses pdbr_pkg, pdbr_cfg_regs,
// pdbr_decoder.
module pulse_distance_byte_receiver_core #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DATA_BITS   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pdbr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pdbr_pkg::THRESH_W-1:0]  cfg_data_i,
  // input samples
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [0] line_level, [7:1] zero
  // received bytes
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] data_byte
  output logic                           m_axis_tlast   // last_of_message
);
  import pdbr_pkg::*;

  pdbr_thresh_t       thresh;
  logic               in_valid_q;
  logic               level_q;
  logic               advance;
  logic               emit;
  logic               last;
  logic [BYTE_W-1:0]  data_byte;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               out_last_q;

  pdbr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thresh_o    (thresh)
  );

  // input stage moves on whenever the output register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      level_q <= s_axis_tdata[0];
    end
  end

  pdbr_decoder #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DATA_BITS   (DATA_BITS)
  ) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .level_i     (level_q),
    .thresh_i    (thresh),
    .emit_o      (emit),
    .data_byte_o (data_byte),
    .last_o      (last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_byte_q <= data_byte;
      out_last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### hw/rtl/pdbr_cfg_regs.sv
// Threshold register file of the pulse-distance byte receiver.
// Depends on pdbr_pkg.
module pdbr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pdbr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pdbr_pkg::THRESH_W-1:0]  cfg_data_i,
  output pdbr_pkg::pdbr_thresh_t         thresh_o
);
  import pdbr_pkg::*;

  pdbr_thresh_t thresh_q, thresh_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    thresh_d = thresh_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MESSAGE_END: thresh_d.message_end = cfg_data_i;
        REG_BYTE_END:    thresh_d.byte_end    = cfg_data_i;
        REG_ONE_BIT:     thresh_d.one_bit     = cfg_data_i;
        REG_ZERO_BIT:    thresh_d.zero_bit    = cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.message_end <= RST_MESSAGE_END;
      thresh_q.byte_end    <= RST_BYTE_END;
      thresh_q.one_bit     <= RST_ONE_BIT;
      thresh_q.zero_bit    <= RST_ZERO_BIT;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  assign thresh_o = thresh_q;

endmodule

### hw/rtl/pdbr_decoder.sv
// Gap measurement, classification and bit shifter of the byte receiver.
// Holds the arm flag, previous level, tick counter and shift register.
// Depends on pdbr_pkg.
module pdbr_decoder #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DATA_BITS   = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         level_i,
  input  pdbr_pkg::pdbr_thresh_t       thresh_i,
  output logic                         emit_o,
  output logic [pdbr_pkg::BYTE_W-1:0]  data_byte_o,
  output logic                         last_o
);
  import pdbr_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

  logic                   armed_q, armed_d;
  logic                   prev_q, prev_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [DATA_BITS-1:0]   shift_q, shift_d;

  logic [COUNT_WIDTH-1:0] gap;
  logic [CMP_W-1:0]       gap_x;
  logic                   edge_det;
  logic                   gt_msg, gt_byte, gt_one, gt_zero;

  assign gap      = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;  // saturating
  assign gap_x    = CMP_W'(gap);
  assign edge_det = level_i != prev_q;
  assign gt_msg   = gap_x > CMP_W'(thresh_i.message_end);
  assign gt_byte  = gap_x > CMP_W'(thresh_i.byte_end);
  assign gt_one   = gap_x > CMP_W'(thresh_i.one_bit);
  assign gt_zero  = gap_x > CMP_W'(thresh_i.zero_bit);

  always_comb begin
    armed_d = armed_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    emit_o  = 1'b0;
    last_o  = 1'b0;
    if (step_i) begin
      if (!armed_q) begin
        if (!level_i) begin
          armed_d = 1'b1;
          prev_d  = 1'b0;
          cnt_d   = '0;
          shift_d = DATA_BITS'(1);  // start marker
        end
      end else begin
        prev_d = level_i;
        if (edge_det) begin
          cnt_d = '0;
          if (gt_msg) begin
            emit_o  = 1'b1;
            last_o  = 1'b1;
            armed_d = 1'b0;
          end else if (gt_byte) begin
            emit_o  = 1'b1;
            shift_d = '0;
          end else if (gt_one) begin
            shift_d = DATA_BITS'({shift_q, 1'b1});
          end else if (gt_zero) begin
            shift_d = DATA_BITS'({shift_q, 1'b0});
          end
        end else begin
          cnt_d = gap;
        end
      end
    end
  end

  assign data_byte_o = BYTE_W'(shift_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      prev_q  <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
    end else begin
      armed_q <= armed_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

`ifndef SYNTHESIS
  a_msg_end_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && last_o |=> !armed_q)
    else $error("receiver still armed after message end");

  a_edge_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && armed_q && edge_det |=> cnt_q == '0)
    else $error("tick counter not restarted on edge");

  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cnt_q) && $stable(shift_q) && $stable(armed_q))
    else $error("decoder state moved without an item");

  a_emit_only_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> armed_q && step_i && edge_det)
    else $error("byte emitted outside an armed edge");
`endif

endmodule
